[design/sitda_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int NUM_DIGITS = 5;
   localparam int NUM_CHARS  = 6;
   localparam int MAG_W      = 16;
   localparam int CHAR_W     = 7;
   localparam int CNT_W      = 3;
   localparam int LEVEL_W    = 3;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

   // k times the place value of each digit position, most significant first
   localparam logic [MAG_W:0] PLACE_MULT [NUM_DIGITS][10] = '{
      '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
        17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
      '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
        17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
      '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
        17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
      '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
        17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
      '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
        17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
   };

   typedef struct packed {
      logic                               negative;
      logic [MAG_W-1:0]                   magnitude;
      logic [0:NUM_DIGITS-1][3:0]         digits;
   } word_type;

endpackage
`default_nettype wire

[design/sitda_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_req_if / sitda_rsp_if
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
interface sitda_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

[design/signed_int_to_decimal_ascii.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Five digit cells in a row each resolve one decimal place per cycle when not
// stalled; the single character register row of the emitter feeds the result
// port. It gives one character per cycle while the output is ready; a text is
// 1 to 6 characters, and the next value is taken as the last character leaves.
// Reset (synchronous, active high) clears all valid bits and the char count.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  wire logic   clock,
   input  wire logic   reset,
   sitda_req_if.sink   req_ch,
   sitda_rsp_if.source rsp_ch
);

   sitda_pkg::word_type word  [sitda_pkg::NUM_DIGITS+1];
   logic                valid [sitda_pkg::NUM_DIGITS+1];
   logic                ready [sitda_pkg::NUM_DIGITS+1];

   // magnitude taken as unsigned, so the most negative value reads as 32768
   always_comb begin
      word[0].negative  = req_ch.value[15];
      word[0].magnitude = req_ch.value[15] ? (~req_ch.value + 16'd1) : req_ch.value;
      word[0].digits    = '0;
   end

   assign valid[0]     = req_ch.valid;
   assign req_ch.ready = ready[0];

   for (genvar i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin : g_cell
      sitda_digit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .level    (sitda_pkg::LEVEL_W'(i)),
         .up_valid (valid[i]),
         .up_ready (ready[i]),
         .up_word  (word[i]),
         .dn_valid (valid[i+1]),
         .dn_ready (ready[i+1]),
         .dn_word  (word[i+1])
      );
   end

   sitda_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (valid[sitda_pkg::NUM_DIGITS]),
      .up_ready     (ready[sitda_pkg::NUM_DIGITS]),
      .up_word      (word[sitda_pkg::NUM_DIGITS]),
      .dn_valid     (rsp_ch.valid),
      .dn_ready     (rsp_ch.ready),
      .dn_char_code (rsp_ch.char_code),
      .dn_last_char (rsp_ch.last_char)
   );

endmodule
`default_nettype wire

[design/sitda_digit_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_digit_cell
// One pipeline cell: extracts the digit of one decimal place and passes
// the remainder on to the next cell.
// ----------------------------------------------------------------------------
module sitda_digit_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [sitda_pkg::LEVEL_W-1:0]       level,
   input  wire logic                                up_valid,
   output logic                                     up_ready,
   input  wire sitda_pkg::word_type                 up_word,
   output logic                                     dn_valid,
   input  wire logic                                dn_ready,
   output sitda_pkg::word_type                      dn_word
);

   logic                 valid_ff;
   logic                 valid_in;
   sitda_pkg::word_type  word_ff;
   sitda_pkg::word_type  word_in;
   logic [3:0]           digit;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // thresholds are monotonic, so the last one met gives the digit
   always_comb begin
      digit = '0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, up_word.magnitude} >= sitda_pkg::PLACE_MULT[level][k]) begin
            digit = 4'(k);
         end
      end
      word_in = up_word;
      word_in.magnitude = sitda_pkg::MAG_W'({1'b0, up_word.magnitude}
                                            - sitda_pkg::PLACE_MULT[level][digit]);
      word_in.digits[level] = digit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule
`default_nettype wire

[design/sitda_emitter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_emitter
// Turns a finished digit word into its text and shifts the characters out,
// one per transaction, through a row of character registers.
// ----------------------------------------------------------------------------
module sitda_emitter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             up_valid,
   output logic                                  up_ready,
   input  wire sitda_pkg::word_type              up_word,
   output logic                                  dn_valid,
   input  wire logic                             dn_ready,
   output logic [sitda_pkg::CHAR_W-1:0]          dn_char_code,
   output logic                                  dn_last_char
);

   logic [sitda_pkg::CNT_W-1:0]  cnt_ff;
   logic [sitda_pkg::CNT_W-1:0]  cnt_in;
   logic [sitda_pkg::CHAR_W-1:0] chars_ff [sitda_pkg::NUM_CHARS];
   logic [sitda_pkg::CHAR_W-1:0] chars_in [sitda_pkg::NUM_CHARS];
   logic [sitda_pkg::CHAR_W-1:0] built    [sitda_pkg::NUM_CHARS];
   logic [sitda_pkg::CNT_W-1:0]  built_cnt;
   logic [sitda_pkg::LEVEL_W-1:0] start;
   logic                          load;
   logic                          pop;

   assign up_ready = (cnt_ff == '0) || ((cnt_ff == sitda_pkg::CNT_W'(1)) && dn_ready);
   assign load     = up_valid && up_ready;
   assign pop      = (cnt_ff != '0) && dn_ready;

   // first significant digit; the ones digit always prints
   always_comb begin
      priority if (up_word.digits[0] != 4'd0) start = 3'd0;
      else if     (up_word.digits[1] != 4'd0) start = 3'd1;
      else if     (up_word.digits[2] != 4'd0) start = 3'd2;
      else if     (up_word.digits[3] != 4'd0) start = 3'd3;
      else                                    start = 3'd4;
   end

   always_comb begin
      logic [3:0] idx;
      idx = '0;
      built_cnt = sitda_pkg::CNT_W'(sitda_pkg::NUM_DIGITS) - start
                  + sitda_pkg::CNT_W'(up_word.negative);
      for (int j = 0; j < sitda_pkg::NUM_CHARS; j++) begin
         idx = 4'(j) + 4'(start) - 4'(up_word.negative);
         if (up_word.negative && (j == 0)) begin
            built[j] = sitda_pkg::CHAR_MINUS;
         end else if (idx < 4'(sitda_pkg::NUM_DIGITS)) begin
            built[j] = sitda_pkg::CHAR_ZERO
                       + sitda_pkg::CHAR_W'(up_word.digits[idx[sitda_pkg::LEVEL_W-1:0]]);
         end else begin
            built[j] = sitda_pkg::CHAR_ZERO;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int j = 0; j < sitda_pkg::NUM_CHARS; j++) begin
         chars_in[j] = chars_ff[j];
      end
      if (load) begin
         cnt_in = built_cnt;
         for (int j = 0; j < sitda_pkg::NUM_CHARS; j++) begin
            chars_in[j] = built[j];
         end
      end else if (pop) begin
         cnt_in = cnt_ff - sitda_pkg::CNT_W'(1);
         for (int j = 0; j < sitda_pkg::NUM_CHARS - 1; j++) begin
            chars_in[j] = chars_ff[j+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < sitda_pkg::NUM_CHARS; j++) begin
         chars_ff[j] <= chars_in[j];
      end
   end

   assign dn_valid     = (cnt_ff != '0);
   assign dn_char_code = chars_ff[0];
   assign dn_last_char = (cnt_ff == sitda_pkg::CNT_W'(1));

endmodule
`default_nettype wire

[verif/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Sends signed 16-bit values and checks each ASCII character of the decimal
// text and its last flag against a predicted character stream. Directed edge
// values come first, then a run with no idling, one long output hold-off and
// random values with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

   localparam int STALL_HOLD = 200;

   typedef struct packed {
      logic [sitda_pkg::CHAR_W-1:0] char_code;
      logic                         last_char;
   } ascii_char_type;

   logic clock;
   logic reset;

   sitda_req_if req_if();
   sitda_rsp_if rsp_if();

   signed_int_to_decimal_ascii dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   ascii_char_type char_expect_q[$];
   int             mismatch_count = 0;
   bit             tx_idle_en     = 1'b1;
   bit             rx_idle_en     = 1'b1;
   int             rx_hold_left   = 0;
   int             rx_stall_left  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   function automatic void predict_text(logic [15:0] value);
      int                          place [sitda_pkg::NUM_DIGITS] = '{10000, 1000, 100, 10, 1};
      logic [sitda_pkg::MAG_W-1:0] mag;
      int                          rest;
      int                          digit;
      bit                          started;
      ascii_char_type              ch;
      // magnitude read as unsigned, so the most negative value gives 32768
      mag     = value[15] ? (~value + 16'd1) : value;
      rest    = mag;
      started = 1'b0;
      if (value[15]) begin
         ch.char_code = sitda_pkg::CHAR_MINUS;
         ch.last_char = 1'b0;
         char_expect_q.push_back(ch);
      end
      for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
         digit = rest / place[i];
         rest  = rest % place[i];
         if (started || digit != 0 || i == sitda_pkg::NUM_DIGITS - 1) begin
            started      = 1'b1;
            ch.char_code = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit);
            ch.last_char = (i == sitda_pkg::NUM_DIGITS - 1);
            char_expect_q.push_back(ch);
         end
      end
   endfunction

   function automatic logic [15:0] random_value();
      int          pow10 [6] = '{1, 10, 100, 1000, 10000, 100000};
      int          sel;
      int          ndig;
      int          lo;
      int          hi;
      int          mag;
      logic [15:0] v;
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
         v = $urandom;
      end else if (sel <= 7) begin
         // pick a digit count first so short and long texts both show up
         ndig = $urandom_range(1, 5);
         lo   = (ndig == 1) ? 0 : pow10[ndig-1];
         hi   = pow10[ndig] - 1;
         if (hi > 32767) hi = 32767;
         mag  = $urandom_range(hi, lo);
         v    = 16'(mag);
         if ($urandom_range(0, 1)) v = -v;
      end else if (sel == 8) begin
         mag = pow10[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1;
         v   = 16'(mag);
         if ($urandom_range(0, 1)) v = -v;
      end else begin
         case ($urandom_range(0, 3))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            default: v = 16'hFFFF;
         endcase
      end
      return v;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, what);
   endtask

   // call at a rising edge; returns at the edge where the transaction is taken
   task automatic send_value(logic [15:0] value);
      int gap;
      gap = tx_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_text(value);
   endtask

   always @(posedge clock) begin : check_chars
      ascii_char_type exp_char;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (char_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                      rsp_if.char_code, rsp_if.last_char));
         end else begin
            exp_char = char_expect_q.pop_front();
            if (rsp_if.char_code !== exp_char.char_code)
               report_mismatch($sformatf("char_code: expected 0x%02h, got 0x%02h",
                                         exp_char.char_code, rsp_if.char_code));
            if (rsp_if.last_char !== exp_char.last_char)
               report_mismatch($sformatf("last_char: expected %0b, got %0b",
                                         exp_char.last_char, rsp_if.last_char));
         end
      end
   end

   // output side ready: long hold-off when requested, else random stalls
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            rx_hold_left--;
         end else if (rx_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rx_stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rx_idle_en) rx_stall_left = pick_gap();
         end
      end
   end

   task automatic test_directed();
      logic [15:0] vals[$] = '{
         16'h0000, 16'h0001, 16'hFFFF, 16'd9, 16'd10, 16'(-10), 16'(-9),
         16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd10001,
         16'h7FFF, 16'h8000, 16'h8001, 16'd12345, 16'(-12345), 16'h5555,
         16'hAAAA, 16'd30000, 16'(-100), 16'd7
      };
      foreach (vals[i]) send_value(vals[i]);
   endtask

   task automatic test_no_idle();
      tx_idle_en    = 1'b0;
      rx_idle_en    = 1'b0;
      rx_stall_left = 0;
      repeat (20) send_value(random_value());
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
   endtask

   // output held off while values keep coming, so the input must stall
   task automatic test_backpressure();
      rx_hold_left = STALL_HOLD;
      repeat (30) send_value(random_value());
   endtask

   task automatic test_random();
      repeat (160) send_value(random_value());
   endtask

   initial begin
      int waited;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.value <= 16'h0000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_idle();
      test_backpressure();
      test_random();

      req_if.valid <= 1'b0;
      waited = 0;
      while (char_expect_q.size() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && char_expect_q.size() == 0) begin
         $display("[signed_int_to_decimal_ascii] OK");
      end else begin
         if (char_expect_q.size() > 0)
            report_mismatch($sformatf("%0d characters never arrived",
                                      char_expect_q.size()));
         $display("[signed_int_to_decimal_ascii] ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
   end

endmodule

[files.f]
design/sitda_pkg.sv
design/sitda_if.sv
design/sitda_digit_cell.sv
design/sitda_emitter.sv
design/signed_int_to_decimal_ascii.sv
verif/tb_signed_int_to_decimal_ascii.sv
